// ----- rtl/core/cht_pkg.sv -----
// Shared types and codes for the chained hash table engine.
// Depends on nothing; every other file of the block imports it.
package cht_pkg;

  localparam logic [2:0] FUNC_ADD    = 3'd0;
  localparam logic [2:0] FUNC_MODIFY = 3'd1;
  localparam logic [2:0] FUNC_DELETE = 3'd2;
  localparam logic [2:0] FUNC_FIND   = 3'd3;
  localparam logic [2:0] FUNC_CLEAR  = 3'd4;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_PRESENT   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam int KeyWidth   = 64;
  localparam int CountWidth = 11;
  localparam int CfgWidth   = 9;

  // Write enables of the three node memories.
  typedef struct packed {
    logic key;
    logic value;
    logic link;
  } node_we_t;

endpackage

// ----- rtl/core/cht_if.sv -----
// Valid/ready channel interfaces for requests and responses.
// Depends on cht_pkg for the field widths.
interface cht_req_if;
  import cht_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  func;
  logic signed [KeyWidth-1:0]  key;
  logic signed [KeyWidth-1:0]  value;
  modport source (output valid, func, key, value, input ready);
  modport sink (input valid, func, key, value, output ready);
endinterface

interface cht_rsp_if;
  import cht_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic signed [KeyWidth-1:0]   found_value;
  logic [CountWidth-1:0]        entry_count;
  modport source (output valid, status, found_value, entry_count, input ready);
  modport sink (input valid, status, found_value, entry_count, output ready);
endinterface

// ----- rtl/core/cht_hash_mod.sv -----
// Bucket index unit: 34*key mod 2^64, then a radix-16 restoring remainder
// by the configured bucket count. Depends on cht_pkg.
module cht_hash_mod import cht_pkg::*; #(
  parameter int MAX_BUCKETS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [KeyWidth-1:0]           key,
  input  logic [CfgWidth-1:0]           num_buckets,
  output logic                          done,
  output logic [((MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1)-1:0] bucket
);
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int StepBits = 4;
  localparam int Steps = KeyWidth / StepBits;
  localparam int SW = $clog2(Steps);
  localparam logic [16:0] MaxB = 17'(MAX_BUCKETS);

  logic                  busy;
  logic [KeyWidth-1:0]   dividend;
  logic [CfgWidth-1:0]   rem;
  logic [CfgWidth-1:0]   rem_next;
  logic [CfgWidth-1:0]   div_n;
  logic [CfgWidth-1:0]   n_eff;
  logic [SW-1:0]         cnt;

  always_comb begin
    if (num_buckets == '0) begin
      n_eff = CfgWidth'(1);
    end else if ({8'b0, num_buckets} > MaxB) begin
      n_eff = MaxB[CfgWidth-1:0];
    end else begin
      n_eff = num_buckets;
    end
  end

  // Four dependent compare/subtract steps per cycle on a 10-bit value.
  always_comb begin
    logic [CfgWidth:0] t;
    rem_next = rem;
    for (int i = 0; i < StepBits; i++) begin
      t = {rem_next, dividend[KeyWidth-1-i]};
      if (t >= {1'b0, div_n}) begin
        t = t - {1'b0, div_n};
      end
      rem_next = t[CfgWidth-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dividend <= (key << 5) + (key << 1);
        rem      <= '0;
        div_n    <= n_eff;
        cnt      <= '0;
        busy     <= 1'b1;
      end else if (busy) begin
        dividend <= dividend << StepBits;
        rem      <= rem_next;
        cnt      <= cnt + SW'(1);
        if (cnt == SW'(Steps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign bucket = BW'(rem);

endmodule

// ----- rtl/core/cht_node_store.sv -----
// Node pool memories: key, value and link (with chain-end valid bit).
// One registered read port, one write port per memory. Depends on cht_pkg.
module cht_node_store import cht_pkg::*; #(
  parameter int POOL_NODES = 1024
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [$clog2(POOL_NODES)-1:0] rd_addr,
  output logic [KeyWidth-1:0]           rd_key,
  output logic [KeyWidth-1:0]           rd_value,
  output logic [$clog2(POOL_NODES):0]   rd_link,
  input  node_we_t                      we,
  input  logic [$clog2(POOL_NODES)-1:0] wr_addr,
  input  logic [KeyWidth-1:0]           wr_key,
  input  logic [KeyWidth-1:0]           wr_value,
  input  logic [$clog2(POOL_NODES):0]   wr_link
);
  localparam int NW = $clog2(POOL_NODES);

  logic [KeyWidth-1:0] key_mem   [POOL_NODES];
  logic [KeyWidth-1:0] value_mem [POOL_NODES];
  logic [NW:0]         link_mem  [POOL_NODES];

  always_ff @(posedge clk) begin
    if (we.key) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (we.value) begin
      value_mem[wr_addr] <= wr_value;
    end
    if (we.link) begin
      link_mem[wr_addr] <= wr_link;
    end
    if (rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_value <= value_mem[rd_addr];
      rd_link  <= link_mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/chained_hash_table_engine_unit.sv -----
// Chained hash table engine: top level with the request sequencer, bucket
// head memory and free-node stack. Depends on cht_pkg, cht_if, cht_hash_mod
// and cht_node_store.
//
// Each request (add, modify, delete, find, clear) gives exactly one response
// with a status and the entry count after the operation. One request is in
// work at a time. A request is taken when idle, then passes the bucket unit
// (a radix-16 remainder of the 64-bit hash by the bucket count), the bucket
// head read, the chain walk at one node per cycle on the node memory read
// port, and the commit, then a link write when an add appends behind an
// existing node. Clear and unused codes go straight to the commit. A
// finished response sits in an output register, so the next request is taken
// while it waits; a commit waits only if the previous response has still not
// been taken. Bucket heads carry a valid bit each, cleared at reset and by
// clear. Node allocation uses a high-water mark plus a stack of freed nodes,
// so no clearing pass over the pool is needed after reset or clear. The
// bucket count register is written through cfg_we and cfg_data; the user
// must do so only while the block is idle, which the block does not enforce.
// Zero acts as one bucket, and values above MAX_BUCKETS act as MAX_BUCKETS.
module chained_hash_table_engine_unit import cht_pkg::*; #(
  parameter int MAX_BUCKETS = 256,
  parameter int POOL_NODES  = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CfgWidth-1:0]  cfg_data,
  cht_req_if.sink              req,
  cht_rsp_if.source            rsp
);
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NW = $clog2(POOL_NODES);
  localparam int CW = $clog2(POOL_NODES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_HASH, S_HEAD, S_NODE, S_COMMIT, S_LINK
  } state_t;

  state_t                 state;
  logic [CfgWidth-1:0]    num_buckets;
  logic [2:0]             func_q;
  logic [KeyWidth-1:0]    key_q;
  logic [KeyWidth-1:0]    value_q;
  logic [BW-1:0]          bucket_q;
  logic [NW-1:0]          cur;
  logic [NW-1:0]          prev;
  logic                   has_prev;
  logic                   hit;
  logic [NW:0]            hit_link;
  logic [KeyWidth-1:0]    found_q;
  logic [NW-1:0]          alloc_q;
  logic [CW-1:0]          count;
  logic [CW-1:0]          high_water;
  logic [CW-1:0]          sp;
  logic [MAX_BUCKETS-1:0] head_valid;

  // Bucket head memory and free-node stack.
  logic [NW-1:0]          head_mem   [MAX_BUCKETS];
  logic [NW-1:0]          free_stack [POOL_NODES];
  logic [NW-1:0]          head_rdata;
  logic [NW-1:0]          stack_rdata;
  logic                   head_we;
  logic [NW-1:0]          head_wdata;
  logic                   stack_we;

  // Bucket unit.
  logic                   div_start;
  logic                   div_done;
  logic [BW-1:0]          div_bucket;

  // Node memory access.
  logic                   node_rd_en;
  logic [NW-1:0]          node_rd_addr;
  logic [KeyWidth-1:0]    nd_key;
  logic [KeyWidth-1:0]    nd_value;
  logic [NW:0]            nd_link;
  node_we_t               node_we;
  logic [NW-1:0]          node_wr_addr;
  logic [NW:0]            node_wr_link;

  // Commit decisions.
  logic                   commit_go;
  logic                   pool_full;
  logic                   add_ok;
  logic                   del_ok;
  logic [NW-1:0]          alloc_idx;
  logic [1:0]             res_status;
  logic [CW-1:0]          res_count;
  logic [KeyWidth-1:0]    res_found;

  assign req.ready = (state == S_IDLE);

  // Only the four keyed operations need a bucket index.
  assign div_start = req.valid && req.ready &&
                     (req.func inside {FUNC_ADD, FUNC_MODIFY, FUNC_DELETE, FUNC_FIND});

  cht_hash_mod #(
    .MAX_BUCKETS (MAX_BUCKETS)
  ) u_hash (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .key         (req.key),
    .num_buckets (num_buckets),
    .done        (div_done),
    .bucket      (div_bucket)
  );

  cht_node_store #(
    .POOL_NODES (POOL_NODES)
  ) u_nodes (
    .clk      (clk),
    .rd_en    (node_rd_en),
    .rd_addr  (node_rd_addr),
    .rd_key   (nd_key),
    .rd_value (nd_value),
    .rd_link  (nd_link),
    .we       (node_we),
    .wr_addr  (node_wr_addr),
    .wr_key   (key_q),
    .wr_value (value_q),
    .wr_link  (node_wr_link)
  );

  // The pool is full exactly when every node holds an entry.
  assign pool_full = (count == CW'(POOL_NODES));
  // Freed nodes are reused first; otherwise the next never-used node.
  assign alloc_idx = (sp != '0) ? stack_rdata : high_water[NW-1:0];
  // The response register must be free before a commit.
  assign commit_go = (state == S_COMMIT) && (!rsp.valid || rsp.ready);
  assign add_ok    = (func_q == FUNC_ADD) && !hit && !pool_full;
  assign del_ok    = (func_q == FUNC_DELETE) && hit;

  // Node memory reads follow the chain one node per cycle.
  always_comb begin
    node_rd_en   = 1'b0;
    node_rd_addr = head_rdata;
    if (state == S_HEAD) begin
      node_rd_en = head_valid[bucket_q];
    end else if (state == S_NODE) begin
      if ((nd_key != key_q) && nd_link[NW]) begin
        node_rd_en   = 1'b1;
        node_rd_addr = nd_link[NW-1:0];
      end
    end
  end

  // Node memory writes: the new node, a changed value or a deleted node's bypass
  // link at commit, then the predecessor's link in S_LINK when an add appends behind a node.
  always_comb begin
    node_we      = '0;
    node_wr_addr = cur;
    node_wr_link = hit_link;
    if (commit_go) begin
      if (add_ok) begin
        node_we      = '{key: 1'b1, value: 1'b1, link: 1'b1};
        node_wr_addr = alloc_idx;
        node_wr_link = '0;
      end else if ((func_q == FUNC_MODIFY) && hit) begin
        node_we.value = 1'b1;
      end else if (del_ok && has_prev) begin
        node_we.link = 1'b1;
        node_wr_addr = prev;
      end
    end else if (state == S_LINK) begin
      node_we.link = 1'b1;
      node_wr_addr = prev;
      node_wr_link = {1'b1, alloc_q};
    end
  end

  // The head changes when an add starts an empty chain or a delete removes
  // the first node.
  always_comb begin
    head_we    = 1'b0;
    head_wdata = alloc_idx;
    stack_we   = commit_go && del_ok;
    if (commit_go && add_ok && !has_prev) begin
      head_we = 1'b1;
    end else if (commit_go && del_ok && !has_prev) begin
      head_we    = 1'b1;
      head_wdata = hit_link[NW-1:0];
    end
  end

  always_comb begin
    res_status = ST_DONE;
    res_count  = count;
    res_found  = '0;
    case (func_q)
      FUNC_ADD: begin
        if (hit) begin
          res_status = ST_PRESENT;
        end else if (pool_full) begin
          res_status = ST_FULL;
        end else begin
          res_count = count + CW'(1);
        end
      end
      FUNC_MODIFY: begin
        if (!hit) begin
          res_status = ST_NOT_FOUND;
        end
      end
      FUNC_DELETE: begin
        if (!hit) begin
          res_status = ST_NOT_FOUND;
        end else if (count != '0) begin
          res_count = count - CW'(1);
        end
      end
      FUNC_FIND: begin
        if (hit) begin
          res_found = found_q;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      FUNC_CLEAR: begin
        res_count = '0;
      end
      default: begin
        res_status = ST_DONE;
      end
    endcase
  end

  // Head memory: read once the bucket is known, written at commit.
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[bucket_q] <= head_wdata;
    end
    if ((state == S_HASH) && div_done) begin
      head_rdata <= head_mem[div_bucket];
    end
  end

  // Free stack: the top is read once the bucket is known, ready for an add's commit.
  always_ff @(posedge clk) begin
    if (stack_we) begin
      free_stack[sp[NW-1:0]] <= cur;
    end
    if ((state == S_HASH) && div_done && (sp != '0)) begin
      stack_rdata <= free_stack[NW'(sp - CW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      num_buckets <= CfgWidth'(256);
      count       <= '0;
      high_water  <= '0;
      sp          <= '0;
      head_valid  <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        num_buckets <= cfg_data;
      end
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            func_q   <= req.func;
            key_q    <= req.key;
            value_q  <= req.value;
            hit      <= 1'b0;
            has_prev <= 1'b0;
            found_q  <= '0;
            state    <= div_start ? S_HASH : S_COMMIT;
          end
        end
        S_HASH: begin
          if (div_done) begin
            bucket_q <= div_bucket;
            state    <= S_HEAD;
          end
        end
        S_HEAD: begin
          cur   <= head_rdata;
          state <= head_valid[bucket_q] ? S_NODE : S_COMMIT;
        end
        S_NODE: begin
          if (nd_key == key_q) begin
            hit      <= 1'b1;
            found_q  <= nd_value;
            hit_link <= nd_link;
            state    <= S_COMMIT;
          end else begin
            prev     <= cur;
            has_prev <= 1'b1;
            cur      <= nd_link[NW-1:0];
            if (!nd_link[NW]) begin
              state <= S_COMMIT;
            end
          end
        end
        S_COMMIT: begin
          if (commit_go) begin
            rsp.valid       <= 1'b1;
            rsp.status      <= res_status;
            rsp.found_value <= res_found;
            rsp.entry_count <= CountWidth'(res_count);
            count           <= res_count;
            state           <= S_IDLE;
            if (add_ok) begin
              alloc_q <= alloc_idx;
              if (sp != '0) begin
                sp <= sp - CW'(1);
              end else begin
                high_water <= high_water + CW'(1);
              end
              if (has_prev) begin
                state <= S_LINK;
              end else begin
                head_valid[bucket_q] <= 1'b1;
              end
            end
            if (del_ok) begin
              sp <= sp + CW'(1);
              if (!has_prev) begin
                head_valid[bucket_q] <= hit_link[NW];
              end
            end
            if (func_q == FUNC_CLEAR) begin
              head_valid <= '0;
              high_water <= '0;
              sp         <= '0;
            end
          end
        end
        S_LINK: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/cht_checker.sv -----
// Port-level checks for the chained hash table engine, bound to the top.
// Depends on cht_pkg and chained_hash_table_engine_unit.
module cht_checker import cht_pkg::*; #(
  parameter int POOL_NODES = 1024
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic [1:0]            status,
  input logic [KeyWidth-1:0]   found_value,
  input logic [CountWidth-1:0] entry_count
);

  // A response waiting for the sink stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  // Only a successful find carries a value.
  a_found_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != ST_DONE) |-> found_value == '0)
    else $error("found value set on a failed request");

  // A full pool is reported only when every node holds an entry.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_FULL) |-> entry_count == CountWidth'(POOL_NODES))
    else $error("pool full reported with free nodes");

  // Reset leaves no response pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind chained_hash_table_engine_unit cht_checker #(
  .POOL_NODES (POOL_NODES)
) u_cht_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .found_value (rsp.found_value),
  .entry_count (rsp.entry_count)
);
